// File: rtl/brb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants for the byte ring buffer: sizes, operation and
// status codes, and the control bundles passed between top level, lanes and
// merge stage.
// ----------------------------------------------------------------------------
package brb_pkg;

  // Store geometry. The store is split into one bank per byte lane.
  localparam int DEPTH  = 256;
  localparam int LANES  = 8;
  localparam int LANE_W = $clog2(LANES);
  localparam int ROWS   = DEPTH / LANES;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = PTR_W + 1;

  // Field widths of one word.
  localparam int OP_W   = 3;
  localparam int LEN_W  = 4;
  localparam int BYTE_W = 8;
  localparam int DATA_W = LANES * BYTE_W;
  localparam int STS_W  = 2;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_PEEK  = 3'd2,
    OP_SKIP  = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  // Result status codes.
  typedef enum logic [STS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_DATA  = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_BAD_LEN  = 2'd3
  } status_t;

  // Access control broadcast to every lane bank.
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [PTR_W-1:0]  wr_ptr;
    logic [PTR_W-1:0]  rd_ptr;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] wr_data;
  } lane_ctrl_t;

  // Result fields that travel alongside the bank read data.
  typedef struct packed {
    status_t           status;
    logic [LEN_W-1:0]  read_count;
    logic [CNT_W-1:0]  fill_level;
    logic [LANE_W-1:0] rot;
  } meta_t;

endpackage

// File: rtl/brb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_req_if / brb_rsp_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface brb_req_if;
  logic                        valid;
  logic                        ready;
  logic [brb_pkg::OP_W-1:0]    op;
  logic [brb_pkg::LEN_W-1:0]   length;
  logic [brb_pkg::DATA_W-1:0]  write_data;

  modport source (output valid, output op, output length, output write_data,
                  input ready);
  modport sink   (input valid, input op, input length, input write_data,
                  output ready);
endinterface

interface brb_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [brb_pkg::STS_W-1:0]   status;
  logic [brb_pkg::DATA_W-1:0]  read_data;
  logic [brb_pkg::LEN_W-1:0]   read_count;
  logic [brb_pkg::CNT_W-1:0]   fill_level;

  modport source (output valid, output status, output read_data,
                  output read_count, output fill_level, input ready);
  modport sink   (input valid, input status, input read_data,
                  input read_count, input fill_level, output ready);
endinterface

// File: rtl/brb_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_lane
// One byte bank of the store. The bank holds every byte whose stream
// position has the lane number in its low bits; it works out its own share of
// a write and its own row of a read from the shared pointers.
// ----------------------------------------------------------------------------
module brb_lane (
  input  logic                         clk,
  input  brb_pkg::lane_ctrl_t          ctrl,
  input  logic [brb_pkg::LANE_W-1:0]   lane_id,
  output logic [brb_pkg::BYTE_W-1:0]   rd_byte
);

  logic [brb_pkg::BYTE_W-1:0] mem [brb_pkg::ROWS];

  logic [brb_pkg::LANE_W-1:0] wr_off;
  logic [brb_pkg::LANE_W-1:0] rd_off;
  logic [brb_pkg::PTR_W-1:0]  wr_addr;
  logic [brb_pkg::PTR_W-1:0]  rd_addr;
  logic [brb_pkg::ROW_W-1:0]  wr_row;
  logic [brb_pkg::ROW_W-1:0]  rd_row;
  logic                       wr_hit;
  logic [brb_pkg::BYTE_W-1:0] wr_byte;

  // Offset of this bank within the word, counted from each pointer.
  assign wr_off  = lane_id - ctrl.wr_ptr[brb_pkg::LANE_W-1:0];
  assign rd_off  = lane_id - ctrl.rd_ptr[brb_pkg::LANE_W-1:0];
  assign wr_addr = ctrl.wr_ptr + brb_pkg::PTR_W'(wr_off);
  assign rd_addr = ctrl.rd_ptr + brb_pkg::PTR_W'(rd_off);
  assign wr_row  = wr_addr[brb_pkg::PTR_W-1:brb_pkg::LANE_W];
  assign rd_row  = rd_addr[brb_pkg::PTR_W-1:brb_pkg::LANE_W];

  // The bank takes a byte only if its offset falls inside the write length.
  assign wr_hit  = ctrl.wr_en && (brb_pkg::LEN_W'(wr_off) < ctrl.length);
  assign wr_byte = ctrl.wr_data[wr_off*brb_pkg::BYTE_W +: brb_pkg::BYTE_W];

  // Bank write port.
  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[wr_row] <= wr_byte;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_byte <= mem[rd_row];
    end
  end

endmodule

// File: rtl/brb_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_merge
// Merging stage. Rotates the lane bytes back into word order, masks the bytes
// past the read count, and holds the result in an output register. A result
// stage in front of the output register lets a new word in while a finished
// result waits.
// ----------------------------------------------------------------------------
module brb_merge (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        load,
  input  brb_pkg::meta_t                              meta,
  input  logic [brb_pkg::LANES-1:0][brb_pkg::BYTE_W-1:0] lane_bytes,
  output logic                                        can_load,
  brb_rsp_if.source                                   rsp
);

  logic                        stage_valid;
  brb_pkg::meta_t              stage_meta;
  logic                        advance;
  logic                        take;
  logic                        out_valid;
  logic [brb_pkg::STS_W-1:0]   out_status;
  logic [brb_pkg::DATA_W-1:0]  out_data;
  logic [brb_pkg::LEN_W-1:0]   out_count;
  logic [brb_pkg::CNT_W-1:0]   out_fill;
  logic [brb_pkg::DATA_W-1:0]  merged;

  assign advance  = !out_valid || rsp.ready;
  assign take     = stage_valid && advance;
  assign can_load = !stage_valid || advance;

  // Put each bank byte back in its place in the word.
  always_comb begin
    merged = '0;
    for (int i = 0; i < brb_pkg::LANES; i++) begin
      if (brb_pkg::LEN_W'(i) < stage_meta.read_count) begin
        merged[i*brb_pkg::BYTE_W +: brb_pkg::BYTE_W] =
          lane_bytes[stage_meta.rot + brb_pkg::LANE_W'(i)];
      end
    end
  end

  // Result stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (load) begin
      stage_valid <= 1'b1;
    end else if (take) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_meta <= meta;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_status <= stage_meta.status;
      out_data   <= merged;
      out_count  <= stage_meta.read_count;
      out_fill   <= stage_meta.fill_level;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.read_data  = out_data;
  assign rsp.read_count = out_count;
  assign rsp.fill_level = out_fill;

endmodule

// File: rtl/byte_ring_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_buffer
// Result path: the bank read and the result stage load when a word is
// accepted, and the output register then takes the result from the result stage.
// Throughput: one word per cycle while the result side keeps ready high;
// the lane banks take all eight bytes of a word in one access.
// Reset: pointers and stored count clear, buffer size returns to 256; the
// byte banks are not cleared and hold nothing readable until written.
// ----------------------------------------------------------------------------
module byte_ring_buffer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        buffer_size_we,
  input  logic [brb_pkg::CNT_W-1:0]   buffer_size,
  brb_req_if.sink                     req,
  brb_rsp_if.source                   rsp
);

  logic [brb_pkg::CNT_W-1:0] size_used;
  logic [brb_pkg::PTR_W-1:0] read_pointer;
  logic [brb_pkg::PTR_W-1:0] read_pointer_next;
  logic [brb_pkg::PTR_W-1:0] write_pointer;
  logic [brb_pkg::PTR_W-1:0] write_pointer_next;
  logic [brb_pkg::CNT_W-1:0] stored_count;
  logic [brb_pkg::CNT_W-1:0] stored_count_next;

  logic                      accept;
  logic                      can_load;
  logic                      do_write;
  logic                      do_advance;
  logic                      do_clear;
  logic [brb_pkg::LEN_W-1:0] rd_count;
  brb_pkg::status_t          status;
  logic [brb_pkg::CNT_W-1:0] free_space;
  logic [brb_pkg::CNT_W-1:0] len_ext;
  logic                      len_over;

  brb_pkg::lane_ctrl_t                                 lane_ctrl;
  brb_pkg::meta_t                                      meta;
  logic [brb_pkg::LANES-1:0][brb_pkg::BYTE_W-1:0]      lane_bytes;

  assign req.ready  = can_load;
  assign accept     = req.valid && req.ready;
  assign len_ext    = brb_pkg::CNT_W'(req.length);
  assign len_over   = req.length > brb_pkg::LEN_W'(brb_pkg::LANES);
  assign free_space = size_used - stored_count;

  // Decode the word and check it against the fill state.
  always_comb begin
    status     = brb_pkg::ST_OK;
    do_write   = 1'b0;
    do_advance = 1'b0;
    do_clear   = 1'b0;
    rd_count   = '0;
    unique case (req.op)
      brb_pkg::OP_WRITE: begin
        if (len_over) begin
          status = brb_pkg::ST_BAD_LEN;
        end else if (req.length != '0) begin
          if (len_ext > free_space) begin
            status = brb_pkg::ST_NO_SPACE;
          end else begin
            do_write = 1'b1;
          end
        end
      end
      brb_pkg::OP_READ, brb_pkg::OP_PEEK, brb_pkg::OP_SKIP: begin
        if (len_over) begin
          status = brb_pkg::ST_BAD_LEN;
        end else if (len_ext > stored_count) begin
          status = brb_pkg::ST_NO_DATA;
        end else begin
          if (req.op != brb_pkg::OP_SKIP) begin
            rd_count = req.length;
          end
          if (req.op != brb_pkg::OP_PEEK) begin
            do_advance = 1'b1;
          end
        end
      end
      brb_pkg::OP_CLEAR: begin
        do_clear = 1'b1;
      end
      default: begin
        status = brb_pkg::ST_OK;
      end
    endcase
  end

  // Pointer and count update for the word.
  always_comb begin
    read_pointer_next  = read_pointer;
    write_pointer_next = write_pointer;
    stored_count_next  = stored_count;
    if (do_clear) begin
      read_pointer_next  = '0;
      write_pointer_next = '0;
      stored_count_next  = '0;
    end else if (do_write) begin
      write_pointer_next = write_pointer + brb_pkg::PTR_W'(req.length);
      stored_count_next  = stored_count + len_ext;
    end else if (do_advance) begin
      read_pointer_next  = read_pointer + brb_pkg::PTR_W'(req.length);
      stored_count_next  = stored_count - len_ext;
    end
  end

  // State registers; a size write drops all stored bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_used     <= brb_pkg::CNT_W'(brb_pkg::DEPTH);
      read_pointer  <= '0;
      write_pointer <= '0;
      stored_count  <= '0;
    end else if (buffer_size_we) begin
      if (buffer_size == '0) begin
        size_used <= brb_pkg::CNT_W'(1);
      end else if (buffer_size > brb_pkg::CNT_W'(brb_pkg::DEPTH)) begin
        size_used <= brb_pkg::CNT_W'(brb_pkg::DEPTH);
      end else begin
        size_used <= buffer_size;
      end
      read_pointer  <= '0;
      write_pointer <= '0;
      stored_count  <= '0;
    end else if (accept) begin
      read_pointer  <= read_pointer_next;
      write_pointer <= write_pointer_next;
      stored_count  <= stored_count_next;
    end
  end

  // Bank access for this word.
  assign lane_ctrl.wr_en   = accept && do_write;
  assign lane_ctrl.rd_en   = accept;
  assign lane_ctrl.wr_ptr  = write_pointer;
  assign lane_ctrl.rd_ptr  = read_pointer;
  assign lane_ctrl.length  = req.length;
  assign lane_ctrl.wr_data = req.write_data;

  for (genvar g = 0; g < brb_pkg::LANES; g++) begin : g_lane
    brb_lane u_lane (
      .clk     (clk),
      .ctrl    (lane_ctrl),
      .lane_id (brb_pkg::LANE_W'(g)),
      .rd_byte (lane_bytes[g])
    );
  end

  // Result fields that follow the bank data into the merge stage.
  assign meta.status     = status;
  assign meta.read_count = rd_count;
  assign meta.fill_level = stored_count_next;
  assign meta.rot        = read_pointer[brb_pkg::LANE_W-1:0];

  brb_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .meta       (meta),
    .lane_bytes (lane_bytes),
    .can_load   (can_load),
    .rsp        (rsp)
  );

endmodule
